### src/rbd_pkg.sv
package rbd_pkg;

   localparam int DEFAULT_DEPTH      = 16;
   localparam int DEFAULT_DATA_WIDTH = 32;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam logic END_FIRST  = 1'b0;
   localparam logic END_SECOND = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic               kind;
      logic               which_end;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic [1:0]         status;
      logic               is_empty;
      logic               is_full;
      logic [3:0]         item_count;
   } rsp_type;

   // One-hot shift command (all zero when nothing shifts) broadcast to every cell of the chain.
   typedef struct packed {
      logic push_first;
      logic pop_first;
      logic push_second;
      logic pop_second;
   } cmd_type;

endpackage

### src/ring_buffer_deque_top.sv
// A request's response word is registered and appears in the cycle after acceptance.
// One request per cycle while the response side does not stall; every request updates
// the whole cell chain at once, and a second-end pop picks the last occupied cell
// by a one-hot select. Reset (synchronous, active high) empties the chain and clears
// the response valid; stored words are not cleared.
module ring_buffer_deque_top
   import rbd_pkg::*;
#(
   parameter int DEPTH      = DEFAULT_DEPTH,
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // The queue holds at most DEPTH-1 words, one per cell. Cell zero is the
   // first end; occupied cells are packed from cell zero upward.
   localparam int CELLS = DEPTH - 1;
   localparam int CW    = $clog2(DEPTH);

   logic                  accept;
   logic                  queue_empty, queue_full;
   logic                  push_ok, pop_ok;
   logic [1:0]            status;
   cmd_type               cmd;
   logic [DATA_WIDTH-1:0] push_word;
   logic [DATA_WIDTH-1:0] tail_word;
   logic [DATA_WIDTH-1:0] pop_word;

   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // valid_chain[CELLS] and data_chain[CELLS] stand for the empty slot past the end
   logic [CELLS:0]                 valid_chain;
   logic [CELLS:0][DATA_WIDTH-1:0] data_chain;

   logic [DATA_WIDTH+31:0] push_ext;
   logic [DATA_WIDTH+31:0] pop_ext;
   logic [CW+3:0]          count_ext;

   // Accept whenever the response register is free or being emptied this cycle.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign queue_empty = (count_ff == '0);
   assign queue_full  = (count_ff == CW'(DEPTH - 1));

   // Fit the 32-bit request value into a stored word.
   assign push_ext  = {{DATA_WIDTH{1'b0}}, req_data.item_value};
   assign push_word = push_ext[DATA_WIDTH-1:0];

   assign push_ok = accept && (req_data.kind == KIND_PUSH) && !queue_full;
   assign pop_ok  = accept && (req_data.kind == KIND_POP) && !queue_empty;

   always_comb begin
      cmd.push_first  = push_ok && (req_data.which_end == END_FIRST);
      cmd.push_second = push_ok && (req_data.which_end == END_SECOND);
      cmd.pop_first   = pop_ok && (req_data.which_end == END_FIRST);
      cmd.pop_second  = pop_ok && (req_data.which_end == END_SECOND);
   end

   assign valid_chain[CELLS] = 1'b0;
   assign data_chain[CELLS]  = '0;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic                  left_valid;
      logic [DATA_WIDTH-1:0] left_data;

      if (i == 0) begin : g_head
         // the head cell's left neighbor is the incoming word
         assign left_valid = 1'b1;
         assign left_data  = push_word;
      end else begin : g_body
         assign left_valid = valid_chain[i-1];
         assign left_data  = data_chain[i-1];
      end

      rbd_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .push_data  (push_word),
         .left_valid (left_valid),
         .left_data  (left_data),
         .right_valid(valid_chain[i+1]),
         .right_data (data_chain[i+1]),
         .valid      (valid_chain[i]),
         .data       (data_chain[i])
      );
   end

   // Pick the last occupied cell: exactly one cell is valid with an empty right
   // neighbor whenever the queue holds anything.
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < CELLS; i++) begin
         if (valid_chain[i] && !valid_chain[i+1]) begin
            tail_word = tail_word | data_chain[i];
         end
      end
   end

   always_comb begin
      pop_word = '0;
      if (pop_ok) begin
         pop_word = (req_data.which_end == END_FIRST) ? data_chain[0] : tail_word;
      end
   end

   assign pop_ext = {32'd0, pop_word};

   always_comb begin
      status = STATUS_DONE;
      if (req_data.kind == KIND_PUSH && queue_full) begin
         status = STATUS_FULL;
      end else if (req_data.kind == KIND_POP && queue_empty) begin
         status = STATUS_EMPTY;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign count_ext = {4'd0, count_in};

   always_comb begin
      rsp_data_in              = rsp_data_ff;
      rsp_valid_in             = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.popped_value = pop_ext[31:0];
         rsp_data_in.status       = status;
         rsp_data_in.is_empty     = (count_in == '0);
         rsp_data_in.is_full      = (count_in == CW'(DEPTH - 1));
         rsp_data_in.item_count   = count_ext[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/rbd_cell.sv
module rbd_cell
   import rbd_pkg::*;
#(
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [DATA_WIDTH-1:0] push_data,
   input  logic                  left_valid,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic                  right_valid,
   input  logic [DATA_WIDTH-1:0] right_data,
   output logic                  valid,
   output logic [DATA_WIDTH-1:0] data
);

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (cmd.push_first) begin
         // shift toward the second end
         valid_in = left_valid;
         data_in  = left_data;
      end else if (cmd.pop_first) begin
         // shift toward the first end
         valid_in = right_valid;
         data_in  = right_data;
      end else if (cmd.push_second) begin
         // first free cell takes the new word
         if (!valid_ff && left_valid) begin
            valid_in = 1'b1;
            data_in  = push_data;
         end
      end else if (cmd.pop_second) begin
         // drop the last occupied cell
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

### src/rbd_checker.sv
module rbd_checker
   import rbd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // every accepted request yields a response next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request gave no response");

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_empty && rsp_data.is_full))
      else $error("queue reported empty and full");

   a_full_refuse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_FULL |-> rsp_data.is_full
         && rsp_data.popped_value == 0)
      else $error("full refusal without full queue");

   a_empty_refuse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_EMPTY |-> rsp_data.is_empty
         && rsp_data.popped_value == 0)
      else $error("empty refusal without empty queue");

endmodule

bind ring_buffer_deque_top rbd_checker u_rbd_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

### dv/rbd_deque_checker.sv
`timescale 1ns / 100ps

module rbd_deque_checker
   import rbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   localparam int SLOTS = DEFAULT_DEPTH;

   logic signed [DEFAULT_DATA_WIDTH-1:0] slot_copy [SLOTS];
   int      first_ptr;
   int      second_ptr;
   rsp_type expected_words [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      first_ptr     = 0;
      second_ptr    = 0;
   end

   function automatic int wrap_up(int p);
      return (p + 1) % SLOTS;
   endfunction

   function automatic int wrap_down(int p);
      return (p + SLOTS - 1) % SLOTS;
   endfunction

   // Apply one request to the shadow deque and build the response word it earns.
   function automatic rsp_type apply_request(req_type r);
      rsp_type w;
      int      held;
      w        = '0;
      w.status = STATUS_DONE;
      if (r.kind == KIND_PUSH) begin
         if (wrap_up(first_ptr) == second_ptr) begin
            w.status = STATUS_FULL;
         end else if (r.which_end == END_FIRST) begin
            first_ptr            = wrap_up(first_ptr);
            slot_copy[first_ptr] = r.item_value;
         end else begin
            slot_copy[second_ptr] = r.item_value;
            second_ptr            = wrap_down(second_ptr);
         end
      end else begin
         if (first_ptr == second_ptr) begin
            w.status = STATUS_EMPTY;
         end else if (r.which_end == END_FIRST) begin
            w.popped_value = slot_copy[first_ptr];
            first_ptr      = wrap_down(first_ptr);
         end else begin
            second_ptr     = wrap_up(second_ptr);
            w.popped_value = slot_copy[second_ptr];
         end
      end
      held         = (first_ptr + SLOTS - second_ptr) % SLOTS;
      w.is_empty   = (first_ptr == second_ptr);
      w.is_full    = (wrap_up(first_ptr) == second_ptr);
      w.item_count = held[3:0];
      return w;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         first_ptr  = 0;
         second_ptr = 0;
         expected_words.delete();
      end else begin
         // Retire the response first: it belongs to an earlier request.
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual %0h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("popped_value", want.popped_value, rsp_data.popped_value);
               check_field("status", want.status, rsp_data.status);
               check_field("is_empty", want.is_empty, rsp_data.is_empty);
               check_field("is_full", want.is_full, rsp_data.is_full);
               check_field("item_count", want.item_count, rsp_data.item_count);
            end
         end
         if (req_valid && !req_stall) begin
            expected_words.push_back(apply_request(req_data));
         end
      end
      pending_count = expected_words.size();
   end

endmodule

### dv/ring_buffer_deque_top_tb.sv
`timescale 1ns / 100ps

module ring_buffer_deque_top_tb;
   import rbd_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int RANDOM_PER_PHASE = 150;
   localparam int DRAIN_CYCLES     = 4;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 18;
   int recv_idle_pct = 75;
   int cycle_count   = 0;
   int fail_count;
   int pending_count;

   ring_buffer_deque_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rbd_deque_checker deque_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #6 clock = ~clock;

   // Stall the response channel at random; the rate follows the current phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Guard against a hung handshake or a response that never comes.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Offer one request word. Call at a falling edge; returns at the falling edge
   // after the word was taken. Valid stays high on return so that back-to-back
   // words never see valid lowered and raised in the same step.
   task automatic send_request(logic kind, logic which_end, logic signed [31:0] value);
      req_type w;
      w.kind       = kind;
      w.which_end  = which_end;
      w.item_value = value;
      // Insert idle cycles before the word, independent of any stall.
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      // Hold the word until an edge sees the stall low.
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Random traffic in runs biased toward pushing, popping or neither, so the
   // deque swings between full and empty and the pointers wrap at both ends.
   task automatic run_random(int count);
      int                 push_pct;
      int                 run_left;
      logic               kind;
      logic               which_end;
      logic signed [31:0] value;
      push_pct = 50;
      run_left = 0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 85;
               1: push_pct = 15;
               default: push_pct = 50;
            endcase
            run_left = $urandom_range(10, 40);
         end
         run_left--;
         kind      = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
         which_end = $urandom_range(0, 1) ? END_SECOND : END_FIRST;
         case ($urandom_range(0, 15))
            0: value = 32'sh8000_0000;
            1: value = 32'sh7fff_ffff;
            2: value = 32'sh0000_0000;
            3: value = 32'shffff_ffff;
            default: value = $urandom();
         endcase
         send_request(kind, which_end, value);
      end
   endtask

   initial begin
      // Hold reset, then release it at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Pop both ends while empty: both refused.
      send_request(KIND_POP, END_FIRST, $urandom());
      send_request(KIND_POP, END_SECOND, $urandom());
      // Push extremes at each end, then pop each back from the end it went in at.
      send_request(KIND_PUSH, END_FIRST, 32'sh8000_0000);
      send_request(KIND_PUSH, END_SECOND, 32'sh7fff_ffff);
      send_request(KIND_POP, END_SECOND, $urandom());
      send_request(KIND_POP, END_FIRST, $urandom());
      // Fill to capacity from alternating ends, wrapping the second-end pointer.
      for (int i = 0; i < DEFAULT_DEPTH - 1; i++) begin
         send_request(KIND_PUSH, (i % 2) ? END_SECOND : END_FIRST,
                      (i == 0) ? 32'shffff_ffff : (i == 1) ? 32'sh0 : $urandom());
      end
      // Push on a full deque at each end: both refused.
      send_request(KIND_PUSH, END_FIRST, $urandom());
      send_request(KIND_PUSH, END_SECOND, $urandom());
      // Pop from a full deque at each end.
      send_request(KIND_POP, END_FIRST, $urandom());
      send_request(KIND_POP, END_SECOND, $urandom());

      run_random(RANDOM_PER_PHASE);
      // Swap the idle rates: the sender now idles often, the receiver rarely.
      send_idle_pct = 75;
      recv_idle_pct = 18;
      run_random(RANDOM_PER_PHASE);
      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(RANDOM_PER_PHASE);
      req_valid <= 1'b0;

      // Drain outstanding responses, then let the pipeline settle.
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
